>>> rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg: shared types, constants and character helpers
// Digit decoding, white space test, parse phases and limits for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

    // width of the running character position inside a string
    localparam int OFFSET_BITS = 16;
    // width of the reported end offset
    localparam int END_BITS    = 16;
    localparam int BASE_BITS   = 6;
    localparam int VALUE_BITS  = 32;

    localparam logic [BASE_BITS-1:0]  BASE_RESET = 6'd10;
    localparam logic [BASE_BITS-1:0]  BASE_OCT   = 6'd8;
    localparam logic [BASE_BITS-1:0]  BASE_DEC   = 6'd10;
    localparam logic [BASE_BITS-1:0]  BASE_HEX   = 6'd16;
    localparam logic [BASE_BITS-1:0]  BASE_AUTO  = 6'd0;

    localparam logic [VALUE_BITS-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_BITS-1:0] VAL_MIN = 32'h8000_0000;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    // one character word as it moves from the input register to the engine
    typedef struct packed {
        logic [7:0] char_in;
        logic       string_start;
    } t_char_word;

    typedef struct packed {
        logic                 is_digit;
        logic [BASE_BITS-1:0] value;
    } t_digit;

    // value of a digit or letter, 0..35
    function automatic t_digit digit_of(input logic [7:0] c);
        t_digit d;
        d.is_digit = 1'b1;
        d.value    = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.value = BASE_BITS'(c - CH_ZERO);
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d.value = BASE_BITS'(c - CH_UA) + BASE_DEC;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d.value = BASE_BITS'(c - CH_LA) + BASE_DEC;
        end else begin
            d.is_digit = 1'b0;
        end
        return d;
    endfunction

    // space, tab, line feed, vertical tab, form feed, carriage return
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

`default_nettype wire

>>> rtl/stp_char_if.sv
// ----------------------------------------------------------------------------
// stp_char_if: character channel
// Valid/ready channel carrying one string character and its start flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       string_start;

    modport source (output valid, output char_in, output string_start, input ready);
    modport sink   (input valid, input char_in, input string_start, output ready);
endinterface

`default_nettype wire

>>> rtl/stp_cfg_if.sv
// ----------------------------------------------------------------------------
// stp_cfg_if: configuration write channel
// Valid/ready channel carrying the number base register write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] number_base;

    modport source (output valid, output number_base, input ready);
    modport sink   (input valid, input number_base, output ready);
endinterface

`default_nettype wire

>>> rtl/stp_result_if.sv
// ----------------------------------------------------------------------------
// stp_result_if: result channel
// Valid/ready channel carrying one parsed number and its status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] parsed_value;
    logic        [15:0] end_offset;
    logic               range_error;
    logic               digits_found;

    modport source (output valid, output parsed_value, output end_offset,
                    output range_error, output digits_found, input ready);
    modport sink   (input valid, input parsed_value, input end_offset,
                    input range_error, input digits_found, output ready);
endinterface

`default_nettype wire

>>> rtl/stp_engine.sv
// ----------------------------------------------------------------------------
// stp_engine: parse state and result register
// Advances the parse by one character per cycle while the result slot is free, and registers each result.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire stp_pkg::t_char_word           i_word,
    input  wire logic [stp_pkg::BASE_BITS-1:0] i_number_base,
    output logic                               o_take,
    stp_result_if.source                       o_result
);
    import stp_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
    localparam int                     T_BITS  = VALUE_BITS + BASE_BITS + 1;

    t_phase                  r_phase, n_phase;
    logic                    r_neg, n_neg;
    logic [BASE_BITS-1:0]    r_base, n_base;
    logic [VALUE_BITS-1:0]   r_acc, n_acc;
    logic                    r_any, n_any;
    logic                    r_ovf, n_ovf;
    logic [OFFSET_BITS-1:0]  r_pos, n_pos;

    logic                    r_out_valid, n_out_valid;
    logic [VALUE_BITS-1:0]   r_out_value, n_out_value;
    logic [END_BITS-1:0]     r_out_end, n_out_end;
    logic                    r_out_ovf, n_out_ovf;
    logic                    r_out_any, n_out_any;

    logic                    step;
    t_digit                  dig;
    logic [T_BITS-1:0]       prod;
    logic [T_BITS-1:0]       lim;
    logic                    do_take;
    logic                    first;
    logic [OFFSET_BITS-1:0]  where;
    logic [31:0]             where_wide;

    // the slot is free when empty or being drained this cycle
    assign o_take = !r_out_valid || o_result.ready;
    assign step   = i_valid && o_take;
    assign dig    = digit_of(i_word.char_in);

    // next state for one character
    always_comb begin
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_base      = r_base;
        n_acc       = r_acc;
        n_any       = r_any;
        n_ovf       = r_ovf;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_value = r_out_value;
        n_out_end   = r_out_end;
        n_out_ovf   = r_out_ovf;
        n_out_any   = r_out_any;
        do_take     = 1'b0;
        first       = 1'b0;
        prod        = '0;
        lim         = '0;
        where       = '0;
        where_wide  = '0;

        if (step) begin
            // a start flag opens a fresh string
            if (i_word.string_start) begin
                n_phase = PH_LEAD;
                n_neg   = 1'b0;
                n_base  = i_number_base;
                n_acc   = '0;
                n_any   = 1'b0;
                n_ovf   = 1'b0;
                n_pos   = '0;
            end

            if (n_phase != PH_IDLE) begin
                where = n_pos;
                if (n_pos < POS_MAX) begin
                    n_pos = n_pos + OFFSET_BITS'(1);
                end

                case (n_phase)
                    PH_LEAD: begin
                        if (is_space(i_word.char_in)) begin
                            n_phase = PH_LEAD;
                        end else if (i_word.char_in == CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = PH_SIGNED;
                        end else if (i_word.char_in == CH_PLUS) begin
                            n_phase = PH_SIGNED;
                        end else begin
                            first = 1'b1;
                        end
                    end
                    PH_SIGNED: begin
                        first = 1'b1;
                    end
                    PH_ZERO: begin
                        if (i_word.char_in == CH_LX || i_word.char_in == CH_UX) begin
                            n_base  = BASE_HEX;
                            n_any   = 1'b0;
                            n_acc   = '0;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DIGITS;
                            do_take = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        do_take = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase

                // first character after white space and sign
                if (first) begin
                    if ((n_base == BASE_AUTO || n_base == BASE_HEX)
                        && i_word.char_in == CH_ZERO) begin
                        n_any   = 1'b1;
                        n_acc   = '0;
                        n_base  = (n_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                        n_phase = PH_ZERO;
                    end else begin
                        if (n_base == BASE_AUTO) begin
                            n_base = BASE_DEC;
                        end
                        n_phase = PH_DIGITS;
                        do_take = 1'b1;
                    end
                end

                // digit accumulate, or end of number
                if (do_take) begin
                    if (dig.is_digit && dig.value < n_base) begin
                        prod = T_BITS'(n_acc) * T_BITS'(n_base) + T_BITS'(dig.value);
                        lim  = T_BITS'(n_neg ? VAL_MIN : VAL_MAX);
                        if (!n_ovf) begin
                            if (prod > lim) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_acc = prod[VALUE_BITS-1:0];
                            end
                        end
                        n_any = 1'b1;
                    end else begin
                        where_wide  = 32'(where);
                        n_out_valid = 1'b1;
                        if (n_ovf) begin
                            n_out_value = n_neg ? VAL_MIN : VAL_MAX;
                        end else begin
                            n_out_value = n_neg ? (VALUE_BITS'(0) - n_acc) : n_acc;
                        end
                        if (!n_any) begin
                            n_out_end = '0;
                        end else if (where_wide > 32'(END_BITS'('1))) begin
                            n_out_end = '1;
                        end else begin
                            n_out_end = where_wide[END_BITS-1:0];
                        end
                        n_out_ovf = n_ovf;
                        n_out_any = n_any;
                        n_phase   = PH_IDLE;
                    end
                end
            end
        end
    end

    // parse state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_neg       <= 1'b0;
            r_base      <= '0;
            r_acc       <= '0;
            r_any       <= 1'b0;
            r_ovf       <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_base      <= n_base;
            r_acc       <= n_acc;
            r_any       <= n_any;
            r_ovf       <= n_ovf;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_end   <= n_out_end;
        r_out_ovf   <= n_out_ovf;
        r_out_any   <= n_out_any;
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.parsed_value = $signed(r_out_value);
    assign o_result.end_offset   = r_out_end;
    assign o_result.range_error  = r_out_ovf;
    assign o_result.digits_found = r_out_any;

endmodule

`default_nettype wire

>>> rtl/string_to_long_parser.sv
// ----------------------------------------------------------------------------
// string_to_long_parser: streaming 32-bit string to integer converter
// Parses signed numbers in bases 2 to 36 or auto-detected from a prefix.
// ----------------------------------------------------------------------------
// One character is accepted every clock cycle. Each word passes an input
// register and then one parse step (a 32 by 6 bit multiply-add with a limit
// compare) that updates the string state; the character that ends a number
// places its result in the output register when the parse step takes it.
// The result register keeps the input flowing while a result waits, and a
// stalled result holds back input only once both stages are full. The base
// register is sampled on each string's first character.
`default_nettype none

module string_to_long_parser (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    stp_char_if.sink     i_char,
    stp_cfg_if.sink      i_cfg,
    stp_result_if.source o_result
);
    import stp_pkg::*;

    logic [BASE_BITS-1:0] r_base_reg;
    logic                 r_in_valid, n_in_valid;
    t_char_word           r_in_word, n_in_word;
    logic                 eng_take;

    // base register, always writable
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_reg <= BASE_RESET;
        end else if (i_cfg.valid) begin
            r_base_reg <= i_cfg.number_base;
        end
    end

    // input register, refilled whenever the engine takes its word
    assign i_char.ready = !r_in_valid || eng_take;

    always_comb begin
        n_in_valid = r_in_valid && !eng_take;
        n_in_word  = r_in_word;
        if (i_char.valid && i_char.ready) begin
            n_in_valid             = 1'b1;
            n_in_word.char_in      = i_char.char_in;
            n_in_word.string_start = i_char.string_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_word <= n_in_word;
    end

    stp_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .i_word        (r_in_word),
        .i_number_base (r_base_reg),
        .o_take        (eng_take),
        .o_result      (o_result)
    );

endmodule

`default_nettype wire

>>> test/string_to_long_parser_test.sv
// ----------------------------------------------------------------------------
// string_to_long_parser_test: self-checking testbench for the string parser
// Streams character words with random idling on both sides. A cycle-free
// model of the parse predicts each number. The monitor checks every result
// word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module string_to_long_parser_test;

    import stp_pkg::*;

    // cycles of quiet before a base write, covering the two pipeline stages
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_CHARS   = 1400;
    // a long run of leading spaces before a number
    localparam int LONG_LEAD      = 40;
    localparam int MAX_PRINTS     = 100;

    typedef enum logic {
        WORD_CHAR,
        WORD_BASE
    } t_word_kind;

    typedef struct {
        t_word_kind           kind;
        logic [7:0]           ch;
        logic                 start;
        logic [BASE_BITS-1:0] base;
        int unsigned          gap;
    } t_pending_word;

    typedef struct {
        logic signed [31:0] value;
        logic        [15:0] offset;
        logic               range_error;
        logic               found;
    } t_number;

    logic i_clk = 1'b0;
    logic i_rst_n;

    stp_char_if   ch_if ();
    stp_cfg_if    base_if ();
    stp_result_if num_if ();

    string_to_long_parser u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (ch_if),
        .i_cfg    (base_if),
        .o_result (num_if)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_pending_word pending_words[$];
    t_number       expected_numbers[$];
    int            error_count = 0;
    int            char_total  = 0;
    logic          tx_calm     = 1'b0;
    logic          rx_calm     = 1'b0;
    logic [BASE_BITS-1:0] gen_base = BASE_RESET;

    // shadow of the parse state
    t_phase               ps_phase = PH_IDLE;
    logic                 ps_neg   = 1'b0;
    logic [BASE_BITS-1:0] ps_base  = '0;
    logic [31:0]          ps_acc   = '0;
    logic                 ps_any   = 1'b0;
    logic                 ps_ovf   = 1'b0;
    logic [15:0]          ps_pos   = '0;
    logic [BASE_BITS-1:0] base_reg = BASE_RESET;

    // ------------------------------------------------------------------------
    // number prediction
    // ------------------------------------------------------------------------

    // digit or letter weight, 255 for anything else
    function automatic int char_weight(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA) + 10;
        return 255;
    endfunction

    function automatic logic white_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    task automatic close_number(input logic [15:0] at);
        t_number num;
        if (ps_ovf) begin
            num.value = ps_neg ? VAL_MIN : VAL_MAX;
        end else begin
            num.value = ps_neg ? (32'd0 - ps_acc) : ps_acc;
        end
        num.offset      = ps_any ? at : 16'd0;
        num.range_error = ps_ovf;
        num.found       = ps_any;
        expected_numbers.push_back(num);
        ps_phase = PH_IDLE;
    endtask

    task automatic take_digit(input logic [7:0] c, input logic [15:0] at);
        int          d;
        logic [63:0] lim;
        logic [63:0] t;
        d = char_weight(c);
        if (d >= int'(ps_base)) begin
            close_number(at);
        end else begin
            if (!ps_ovf) begin
                lim = ps_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                t   = 64'(ps_acc) * 64'(ps_base) + 64'(d);
                if (t > lim) ps_ovf = 1'b1;
                else ps_acc = t[31:0];
            end
            ps_any = 1'b1;
        end
    endtask

    // first character after spaces and sign: prefix zero or a digit
    task automatic first_digit(input logic [7:0] c, input logic [15:0] at);
        if ((ps_base == BASE_AUTO || ps_base == BASE_HEX) && c == CH_ZERO) begin
            ps_any   = 1'b1;
            ps_acc   = '0;
            ps_base  = (ps_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
            ps_phase = PH_ZERO;
        end else begin
            if (ps_base == BASE_AUTO) ps_base = BASE_DEC;
            ps_phase = PH_DIGITS;
            take_digit(c, at);
        end
    endtask

    task automatic predict_char(input logic [7:0] c, input logic start);
        logic [15:0] at;
        if (start) begin
            ps_phase = PH_LEAD;
            ps_neg   = 1'b0;
            ps_base  = base_reg;
            ps_acc   = '0;
            ps_any   = 1'b0;
            ps_ovf   = 1'b0;
            ps_pos   = '0;
        end else if (ps_phase == PH_IDLE) begin
            return;
        end
        at = ps_pos;
        if (ps_pos != 16'hFFFF) ps_pos = ps_pos + 16'd1;
        case (ps_phase)
            PH_LEAD: begin
                if (white_space(c)) begin
                end else if (c == CH_MINUS) begin
                    ps_neg   = 1'b1;
                    ps_phase = PH_SIGNED;
                end else if (c == CH_PLUS) begin
                    ps_phase = PH_SIGNED;
                end else begin
                    first_digit(c, at);
                end
            end
            PH_SIGNED: first_digit(c, at);
            PH_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    ps_base  = BASE_HEX;
                    ps_any   = 1'b0;
                    ps_acc   = '0;
                    ps_phase = PH_DIGITS;
                end else begin
                    ps_phase = PH_DIGITS;
                    take_digit(c, at);
                end
            end
            default: take_digit(c, at);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------

    // idle length: mostly short, now and then long
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_gap();
        if (tx_calm) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        return pick_len();
    endfunction

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10) return 8'(CH_ZERO + v);
        return 8'(($urandom_range(0, 1) ? CH_UA : CH_LA) + v - 10);
    endfunction

    function automatic logic [7:0] space_char();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return 8'h0A;
            3: return 8'h0B;
            4: return 8'h0C;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [BASE_BITS-1:0] pick_base();
        case ($urandom_range(0, 9))
            0: return BASE_AUTO;
            1: return 6'd63;
            2: return 6'd1;
            3: return 6'd2;
            4: return BASE_HEX;
            5: return 6'd36;
            6: return BASE_OCT;
            7: return BASE_DEC;
            default: return BASE_BITS'($urandom_range(0, 63));
        endcase
    endfunction

    task automatic add_char(input logic [7:0] c, input logic start);
        t_pending_word w;
        w.kind  = WORD_CHAR;
        w.ch    = c;
        w.start = start;
        w.base  = '0;
        w.gap   = pick_gap();
        pending_words.push_back(w);
        char_total++;
    endtask

    task automatic add_base(input logic [BASE_BITS-1:0] b);
        t_pending_word w;
        w.kind  = WORD_BASE;
        w.ch    = '0;
        w.start = 1'b0;
        w.base  = b;
        w.gap   = pick_gap();
        pending_words.push_back(w);
        gen_base = b;
    endtask

    task automatic add_text(input string s, input logic fresh);
        for (int i = 0; i < s.len(); i++) begin
            add_char(s[i], fresh && (i == 0));
        end
    endtask

    // one well-formed number with random spacing, sign, prefix and magnitude
    task automatic add_number();
        logic        fresh;
        int          eb;
        int          mode;
        logic [63:0] mag;
        logic [7:0]  digs[$];
        logic [7:0]  c;
        fresh = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                add_char(space_char(), fresh);
                fresh = 1'b0;
            end
        end
        case ($urandom_range(0, 3))
            0: begin add_char(CH_MINUS, fresh); fresh = 1'b0; end
            1: begin add_char(CH_PLUS, fresh); fresh = 1'b0; end
            default: ;
        endcase
        // prefix according to the base that will be latched
        if (gen_base == BASE_AUTO) begin
            case ($urandom_range(0, 2))
                0: begin
                    add_char(CH_ZERO, fresh);
                    add_char($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b0);
                    eb = 16;
                end
                1: begin
                    add_char(CH_ZERO, fresh);
                    eb = 8;
                end
                default: eb = 10;
            endcase
            fresh = fresh && (eb == 10);
        end else if (gen_base == BASE_HEX && $urandom_range(0, 2) == 0) begin
            add_char(CH_ZERO, fresh);
            add_char($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b0);
            fresh = 1'b0;
            eb = 16;
        end else begin
            eb = (gen_base > 6'd36) ? 36 : int'(gen_base);
        end
        mode = $urandom_range(0, 9);
        case (mode)
            0, 1, 2: mag = 64'($urandom_range(0, 40));
            3, 4, 5: mag = 64'($urandom);
            6, 7:    mag = 64'h7FFF_FFFE + 64'($urandom_range(0, 3));
            8:       mag = {32'($urandom), 32'($urandom)};
            default: mag = '0;
        endcase
        // digits, or now and then none at all for a bare prefix or sign
        if ($urandom_range(0, 19) != 0) begin
            if (eb <= 1) begin
                repeat ($urandom_range(1, 5)) digs.push_back(CH_ZERO);
            end else begin
                do begin
                    digs.push_front(digit_char(int'(mag % 64'(eb))));
                    mag = mag / 64'(eb);
                end while (mag != 0);
            end
        end
        foreach (digs[i]) begin
            add_char(digs[i], fresh);
            fresh = 1'b0;
        end
        // an abandoned number is dropped by the next string start
        if ($urandom_range(0, 19) == 0) return;
        case ($urandom_range(0, 5))
            0: c = CH_SPACE;
            1: c = 8'h2C;
            2: c = 8'h00;
            3: c = 8'hFF;
            4: c = 8'h2E;
            default: c = 8'($urandom_range(0, 255));
        endcase
        add_char(c, fresh);
        repeat ($urandom_range(0, 2)) add_char(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTS) begin
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        end
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // driver: character and base words from the pending queue
    // ------------------------------------------------------------------------
    int gap_left     = 0;
    int settle_count = 0;

    always @(posedge i_clk) begin : b_driver
        logic char_busy;
        logic base_busy;
        if (!i_rst_n) begin
            ch_if.valid   <= 1'b0;
            base_if.valid <= 1'b0;
        end else begin
            char_busy = ch_if.valid;
            base_busy = base_if.valid;
            if (ch_if.valid && ch_if.ready) begin
                predict_char(ch_if.char_in, ch_if.string_start);
                void'(pending_words.pop_front());
                char_busy = 1'b0;
                gap_left  = (pending_words.size() > 0) ? pending_words[0].gap : 0;
            end
            if (base_if.valid && base_if.ready) begin
                base_reg = base_if.number_base;
                void'(pending_words.pop_front());
                base_busy = 1'b0;
                gap_left  = (pending_words.size() > 0) ? pending_words[0].gap : 0;
            end
            // base writes wait for an empty pipeline
            if (expected_numbers.size() == 0 && !ch_if.valid) begin
                if (settle_count < SETTLE_CYCLES) settle_count++;
            end else begin
                settle_count = 0;
            end
            if (!char_busy && !base_busy && pending_words.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words[0].kind == WORD_CHAR) begin
                    char_busy = 1'b1;
                    ch_if.char_in      <= pending_words[0].ch;
                    ch_if.string_start <= pending_words[0].start;
                end else if (settle_count >= SETTLE_CYCLES) begin
                    base_busy = 1'b1;
                    base_if.number_base <= pending_words[0].base;
                end
            end
            ch_if.valid   <= char_busy;
            base_if.valid <= base_busy;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: result words against predictions, with random back-pressure
    // ------------------------------------------------------------------------
    int rx_hold = 0;

    always @(posedge i_clk) begin : b_monitor
        t_number want;
        if (!i_rst_n) begin
            num_if.ready <= 1'b0;
        end else begin
            if (num_if.valid && num_if.ready) begin
                if (expected_numbers.size() == 0) begin
                    report_mismatch("unexpected result", num_if.parsed_value, '0);
                end else begin
                    want = expected_numbers.pop_front();
                    if (num_if.parsed_value !== want.value)
                        report_mismatch("parsed_value", num_if.parsed_value, want.value);
                    if (num_if.end_offset !== want.offset)
                        report_mismatch("end_offset", 32'(num_if.end_offset),
                                        32'(want.offset));
                    if (num_if.range_error !== want.range_error)
                        report_mismatch("range_error", 32'(num_if.range_error),
                                        32'(want.range_error));
                    if (num_if.digits_found !== want.found)
                        report_mismatch("digits_found", 32'(num_if.digits_found),
                                        32'(want.found));
                end
            end
            if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
            if (rx_hold == 0 && !rx_calm && $urandom_range(0, 7) == 0) rx_hold = pick_len();
            if (rx_hold > 0) begin
                rx_hold--;
                num_if.ready <= 1'b0;
            end else begin
                num_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles without any accepted word
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((ch_if.valid && ch_if.ready) || (base_if.valid && base_if.ready) ||
                (num_if.valid && num_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int random_goal;
        i_rst_n             = 1'b0;
        ch_if.valid         = 1'b0;
        ch_if.char_in       = '0;
        ch_if.string_start  = 1'b0;
        base_if.valid       = 1'b0;
        base_if.number_base = '0;
        num_if.ready        = 1'b0;

        // directed: stray character before any string
        add_char(8'h51, 1'b0);
        // white space and sign, then a terminating letter
        add_text("\t-42z", 1'b1);
        // open number dropped by a new string start
        add_text("+7", 1'b1);
        // decimal zero ended by x
        add_text("0x", 1'b1);
        // bare hexadecimal prefix
        add_base(BASE_HEX);
        add_text("0xg", 1'b1);
        // auto base picks octal after a zero
        add_base(BASE_AUTO);
        add_text("0779", 1'b1);
        // base write in the middle of a string applies to the next one
        add_text("12", 1'b1);
        add_base(6'd36);
        add_text("3!", 1'b0);
        // every letter a digit, overflow, high byte as terminator
        add_base(6'd63);
        add_text("-zzzzzz", 1'b1);
        add_char(8'h80, 1'b0);
        // base one: only zero is a digit
        add_base(6'd1);
        add_text("00", 1'b1);
        add_char(8'hFF, 1'b0);

        // long run of leading spaces, then an overflowing negative number
        tx_calm = 1'b1;
        add_base(BASE_DEC);
        add_char(CH_SPACE, 1'b1);
        repeat (LONG_LEAD - 1) add_char(CH_SPACE, 1'b0);
        add_char(CH_MINUS, 1'b0);
        repeat (12) add_char(CH_NINE, 1'b0);
        add_char(8'h21, 1'b0);
        tx_calm = 1'b0;

        // random: mostly well-formed numbers, some noise
        random_goal = char_total + RANDOM_CHARS;
        while (char_total < random_goal) begin
            if ($urandom_range(0, 29) == 0) add_base(pick_base());
            if ($urandom_range(0, 9) == 0) tx_calm = !tx_calm;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end else begin
                add_number();
            end
        end
        add_base(6'd63);
        add_base(BASE_RESET);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || expected_numbers.size() != 0 ||
               ch_if.valid || base_if.valid) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
